/* hw/rtl/tbs_pkg.sv */
// Shared types, constants and the byte classifier for the token splitter.
// No dependencies; used by every module of the block.
`default_nettype none

package tbs_pkg;

    localparam int LENGTH_BITS = 10;
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_BITS = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = 1;
    localparam int QCNT_BITS = 2;

    localparam logic [LENGTH_BITS-1:0] LIMIT_RESET = LENGTH_BITS'((1 << LENGTH_BITS) - 1);

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;
    localparam logic [1:0] ERR_UNTERM   = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_STRING,
        MODE_LT,
        MODE_GT
    } t_mode;

    typedef enum logic [2:0] {
        CLS_BLANK,
        CLS_OP,
        CLS_QUOTE,
        CLS_LT,
        CLS_GT,
        CLS_WORD,
        CLS_BAD
    } t_cls;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       tend;
        logic [1:0] err;
    } t_res;

    typedef struct packed {
        t_res [MAX_RESULTS-1:0]  res;
        logic [RES_CNT_BITS-1:0] cnt;
        logic                    last;
    } t_bundle;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls k;
        case (c) inside
            8'h20, 8'h09, 8'h0D, 8'h0C, 8'h0B: k = CLS_BLANK;
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h5E, 8'h3D, 8'h2C, 8'h0A: k = CLS_OP;
            CH_QUOTE: k = CLS_QUOTE;
            CH_LT: k = CLS_LT;
            CH_GT: k = CLS_GT;
            [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h5F, 8'h2E: k = CLS_WORD;
            default: k = CLS_BAD;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tbs_front.sv */
// Front end: takes text bytes, classifies them, tracks lexer state and
// builds the bundle of results for each byte. Uses tbs_pkg.
`default_nettype none

module tbs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tbs_pkg::LENGTH_BITS-1:0] i_cfg_wr_data,
    input  wire logic                          i_valid,
    input  wire logic [7:0]                    i_byte,
    input  wire logic                          i_last,
    input  wire logic                          i_q_full,
    output logic                               o_ready,
    output logic                               o_push,
    output tbs_pkg::t_bundle                   o_bundle
);

    localparam int LB = tbs_pkg::LENGTH_BITS;

    tbs_pkg::t_mode        r_mode, n_mode, w_mode_mid;
    logic [LB-1:0]         r_cnt, n_cnt;
    logic                  r_halt, n_halt;
    logic [LB-1:0]         r_max;
    tbs_pkg::t_cls         w_cls;
    logic [1:0]            w_err;
    logic                  f_sign, f_sign_end, f_close, f_char, f_char_end;
    logic                  f_end_sign, f_end_close, f_bare;
    logic                  w_accept;

    assign w_cls    = tbs_pkg::classify(i_byte);
    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // next state and emit flags
    always_comb begin
        logic [LB-1:0] cur;
        logic          run_norm;
        logic          pair;
        cur         = r_cnt;
        run_norm    = 1'b0;
        pair        = 1'b0;
        w_mode_mid  = r_mode;
        w_err       = tbs_pkg::ERR_NONE;
        f_sign      = 1'b0;
        f_sign_end  = 1'b0;
        f_close     = 1'b0;
        f_char      = 1'b0;
        f_char_end  = 1'b0;
        f_end_sign  = 1'b0;
        f_end_close = 1'b0;
        f_bare      = 1'b0;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_halt      = r_halt;
        if (r_halt) begin
            if (i_last) begin
                f_bare = 1'b1;
                n_mode = tbs_pkg::MODE_NORMAL;
                n_cnt  = '0;
                n_halt = 1'b0;
            end
        end else begin
            case (r_mode)
                tbs_pkg::MODE_LT, tbs_pkg::MODE_GT: begin
                    pair = (i_byte == tbs_pkg::CH_EQ) ||
                           (r_mode == tbs_pkg::MODE_LT && i_byte == tbs_pkg::CH_GT);
                    f_sign     = 1'b1;
                    w_mode_mid = tbs_pkg::MODE_NORMAL;
                    cur        = '0;
                    if (pair) begin
                        f_char     = 1'b1;
                        f_char_end = 1'b1;
                    end else begin
                        f_sign_end = 1'b1;
                        run_norm   = 1'b1;
                    end
                end
                tbs_pkg::MODE_STRING: begin
                    if (i_byte == tbs_pkg::CH_NUL) begin
                        w_err = tbs_pkg::ERR_INVALID;
                    end else if ({1'b0, r_cnt} + (LB+1)'(1) >= {1'b0, r_max}) begin
                        w_err = tbs_pkg::ERR_TOO_LONG;
                    end else begin
                        cur    = r_cnt + LB'(1);
                        f_char = 1'b1;
                        if (i_byte == tbs_pkg::CH_QUOTE) begin
                            f_char_end = 1'b1;
                            w_mode_mid = tbs_pkg::MODE_NORMAL;
                            cur        = '0;
                        end
                    end
                end
                default: run_norm = 1'b1;
            endcase

            if (run_norm) begin
                case (w_cls)
                    tbs_pkg::CLS_BLANK: begin
                        f_close = (cur != '0);
                        cur     = '0;
                    end
                    tbs_pkg::CLS_OP: begin
                        f_close    = (cur != '0);
                        cur        = '0;
                        f_char     = 1'b1;
                        f_char_end = 1'b1;
                    end
                    tbs_pkg::CLS_QUOTE: begin
                        f_close    = (cur != '0);
                        f_char     = 1'b1;
                        w_mode_mid = tbs_pkg::MODE_STRING;
                        cur        = LB'(1);
                    end
                    tbs_pkg::CLS_LT: begin
                        f_close    = (cur != '0);
                        cur        = '0;
                        w_mode_mid = tbs_pkg::MODE_LT;
                    end
                    tbs_pkg::CLS_GT: begin
                        f_close    = (cur != '0);
                        cur        = '0;
                        w_mode_mid = tbs_pkg::MODE_GT;
                    end
                    tbs_pkg::CLS_WORD: begin
                        if (cur >= r_max) begin
                            w_err = tbs_pkg::ERR_TOO_LONG;
                        end else begin
                            f_char = 1'b1;
                            cur    = cur + LB'(1);
                        end
                    end
                    default: w_err = tbs_pkg::ERR_INVALID;
                endcase
            end

            if (w_err == tbs_pkg::ERR_NONE && i_last) begin
                if (w_mode_mid == tbs_pkg::MODE_STRING) begin
                    w_err = tbs_pkg::ERR_UNTERM;
                end else if (w_mode_mid == tbs_pkg::MODE_LT ||
                             w_mode_mid == tbs_pkg::MODE_GT) begin
                    f_end_sign = 1'b1;
                end else begin
                    f_end_close = (cur != '0);
                end
            end

            if (w_err != tbs_pkg::ERR_NONE) begin
                n_mode = tbs_pkg::MODE_NORMAL;
                n_cnt  = '0;
                n_halt = !i_last;
            end else if (i_last) begin
                f_bare = !(f_sign || f_close || f_char || f_end_sign || f_end_close);
                n_mode = tbs_pkg::MODE_NORMAL;
                n_cnt  = '0;
            end else begin
                n_mode = w_mode_mid;
                n_cnt  = cur;
            end
        end
    end

    // result bundle in emission order
    always_comb begin
        logic [tbs_pkg::RES_CNT_BITS-1:0] k;
        k        = '0;
        o_bundle = '0;
        if (f_sign) begin
            o_bundle.res[k[1:0]] = '{ch: (r_mode == tbs_pkg::MODE_LT) ? tbs_pkg::CH_LT
                                                                    : tbs_pkg::CH_GT,
                                     valid: 1'b1, tend: f_sign_end, err: tbs_pkg::ERR_NONE};
            k = k + 3'd1;
        end
        if (f_close) begin
            o_bundle.res[k[1:0]] = '{ch: 8'h00, valid: 1'b0, tend: 1'b1,
                                     err: tbs_pkg::ERR_NONE};
            k = k + 3'd1;
        end
        if (f_char) begin
            o_bundle.res[k[1:0]] = '{ch: i_byte, valid: 1'b1, tend: f_char_end,
                                     err: tbs_pkg::ERR_NONE};
            k = k + 3'd1;
        end
        if (f_end_sign) begin
            o_bundle.res[k[1:0]] = '{ch: (w_mode_mid == tbs_pkg::MODE_LT) ? tbs_pkg::CH_LT
                                                                        : tbs_pkg::CH_GT,
                                     valid: 1'b1, tend: 1'b1, err: tbs_pkg::ERR_NONE};
            k = k + 3'd1;
        end
        if (f_end_close) begin
            o_bundle.res[k[1:0]] = '{ch: 8'h00, valid: 1'b0, tend: 1'b1,
                                     err: tbs_pkg::ERR_NONE};
            k = k + 3'd1;
        end
        if (w_err != tbs_pkg::ERR_NONE) begin
            o_bundle.res[k[1:0]] = '{ch: 8'h00, valid: 1'b0, tend: 1'b0, err: w_err};
            k = k + 3'd1;
        end
        if (f_bare) begin
            o_bundle.res[k[1:0]] = '{ch: 8'h00, valid: 1'b0, tend: 1'b0,
                                     err: tbs_pkg::ERR_NONE};
            k = k + 3'd1;
        end
        o_bundle.cnt  = k;
        o_bundle.last = i_last;
    end

    assign o_push = w_accept && (o_bundle.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tbs_pkg::MODE_NORMAL;
            r_cnt  <= '0;
            r_halt <= 1'b0;
            r_max  <= tbs_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_halt <= n_halt;
            end
        end
    end

    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (r_mode == tbs_pkg::MODE_NORMAL && r_cnt == '0))
        else $error("halted with open token state");

    a_sign_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == tbs_pkg::MODE_LT || r_mode == tbs_pkg::MODE_GT) |-> r_cnt == '0)
        else $error("pending sign with nonzero count");

endmodule

`default_nettype wire

/* hw/rtl/tbs_queue.sv */
// Small bundle queue between the front end and the result sequencer.
// Uses tbs_pkg for the bundle type and depth.
`default_nettype none

module tbs_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire tbs_pkg::t_bundle i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output tbs_pkg::t_bundle      o_data
);

    tbs_pkg::t_bundle                r_mem [tbs_pkg::QUEUE_DEPTH];
    logic [tbs_pkg::QPTR_BITS-1:0]   r_wr, r_rd;
    logic [tbs_pkg::QCNT_BITS-1:0]   r_count;

    assign o_full  = (r_count == tbs_pkg::QCNT_BITS'(tbs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + tbs_pkg::QCNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - tbs_pkg::QCNT_BITS'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tbs_pkg::QCNT_BITS'(tbs_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* hw/rtl/tbs_back.sv */
// Back end: walks the results of the head bundle one per cycle, while the
// output is not stalled, into the output register. Uses tbs_pkg.
`default_nettype none

module tbs_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire tbs_pkg::t_bundle  i_q_data,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  wire logic              i_tready,
    output logic [15:0]            o_tdata,
    output logic                   o_tlast
);

    logic [1:0]      r_idx;
    tbs_pkg::t_res   r_out;
    logic            r_out_last;
    logic            r_out_done;
    logic            r_out_valid;
    logic            w_load;
    logic            w_is_last;

    assign w_load    = !r_out_valid || i_tready;
    assign w_is_last = ({1'b0, r_idx} + 3'd1) == i_q_data.cnt;
    assign o_pop     = w_load && i_q_valid && w_is_last;

    always_ff @(posedge i_clk) begin
        if (w_load && i_q_valid) begin
            r_out      <= i_q_data.res[r_idx];
            r_out_last <= w_is_last;
            r_out_done <= w_is_last && i_q_data.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= w_is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {3'b000, r_out_last, r_out.err, r_out.tend, r_out.valid, r_out.ch};
    assign o_tlast  = r_out_done;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("text done on a non-final result");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_q_valid && i_q_data.cnt != '0))
        else $error("pop of empty or zero-length bundle");

endmodule

`default_nettype wire

/* hw/rtl/basic_token_splitter_top.sv */
// Top level of the token splitter: front end, bundle queue, result sequencer.
// Depends on tbs_pkg, tbs_front, tbs_queue and tbs_back.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata[7:0] in_byte, tlast text_last
//  m_axis   | out | tdata: out_char, char_valid, token_end, error_code, last_result
//           |     | tlast text_done
//  cfg      | in  | wr_data[9:0] max_token_length, written when wr_en is high
//
// One byte is taken per cycle while the two-entry bundle queue has room.
// The output register emits one result per cycle while the consumer accepts, so
// n results take n transfers; results pass the bundle queue, then the output
// register. Synchronous active-low reset clears lexer state, queue and output
// valid; the length limit returns to 1023. Either side may stall independently.
`default_nettype none

module basic_token_splitter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [9:0]  i_cfg_wr_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] out_char, [8] char_valid, [9] token_end, [11:10] error_code,
    // [12] last_result, [15:13] zero
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    logic             w_push, w_pop, w_full, w_q_valid;
    tbs_pkg::t_bundle w_push_data, w_head;

    tbs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .i_byte        (i_s_axis_tdata),
        .i_last        (i_s_axis_tlast),
        .i_q_full      (w_full),
        .o_ready       (o_s_axis_tready),
        .o_push        (w_push),
        .o_bundle      (w_push_data)
    );

    tbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_head)
    );

    tbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_head),
        .o_pop     (w_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
